/* rtl/csmac_pkg.sv */
// Shared types, constants and the small modular fold for the chain-and-sum MAC.
// Used by every module of the block; depends on nothing else.
package csmac_pkg;

    localparam int WORD_W    = 32;
    localparam int RES_W     = 31;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int S_DATA_W  = 2 * WORD_W;
    localparam int M_DATA_W  = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [RES_W-1:0]  MOD_P   = 31'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MIX_KEY = 32'h0E79_A9C1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHAIN_MULT = 2'd0,
        CFG_CHAIN_ADD  = 2'd1,
        CFG_SUM_MULT   = 2'd2,
        CFG_SUM_ADD    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_MUL,
        ST_MIX_RED,
        ST_CHN_MUL,
        ST_CHN_RED,
        ST_SUM_PREP,
        ST_SUM_MUL,
        ST_SUM_RED,
        ST_UPDATE,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] chain_mult;
        logic [WORD_W-1:0] chain_add;
        logic [WORD_W-1:0] sum_mult;
        logic [WORD_W-1:0] sum_add;
    } keys_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] d;
    } mul_op_t;

    // Reduces any value below 2^33 modulo 2^31-1.
    function automatic logic [RES_W-1:0] fold_add(input logic [RES_W+1:0] x);
        logic [RES_W:0] s;
        s = {1'b0, x[RES_W-1:0]} + {{(RES_W-1){1'b0}}, x[RES_W+1:RES_W]};
        if (s >= {1'b0, MOD_P}) begin
            fold_add = RES_W'(s - {1'b0, MOD_P});
        end else begin
            fold_add = s[RES_W-1:0];
        end
    endfunction

endpackage

/* rtl/csmac_mulred.sv */
// Shared multiply-and-reduce unit: res = (a * b + d) mod 2^31-1.
// The product is registered, then folded and reduced. Depends on csmac_pkg.
module csmac_mulred (
    input  logic                        aclk,
    input  csmac_pkg::mul_op_t          op,
    output logic [csmac_pkg::RES_W-1:0] res
);
    import csmac_pkg::*;

    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [WORD_W-1:0]   d_reg;
    logic [RES_W+3:0]    fold1;
    logic [RES_W:0]      fold2;
    logic [RES_W-1:0]    res_reg;
    logic [RES_W-1:0]    res_next;

    assign prod_next = PROD_W'(op.a) * PROD_W'(op.b);

    always_comb begin
        fold1 = (RES_W+4)'(prod_reg[RES_W-1:0]) + (RES_W+4)'(prod_reg[PROD_W-1:RES_W])
              + (RES_W+4)'(d_reg);
        fold2 = (RES_W+1)'(fold1[RES_W-1:0]) + (RES_W+1)'(fold1[RES_W+3:RES_W]);
        res_next = fold_add({1'b0, fold2});
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        d_reg    <= op.d;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

/* rtl/csmac_keys.sv */
// Key register file of the MAC: four 32-bit keys written over the configuration channel.
// Depends on csmac_pkg.
module csmac_keys (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csmac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csmac_pkg::WORD_W-1:0]    cfg_data,
    output csmac_pkg::keys_t                keys
);
    import csmac_pkg::*;

    keys_t keys_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CHAIN_MULT: keys_reg.chain_mult <= cfg_data;
                CFG_CHAIN_ADD:  keys_reg.chain_add  <= cfg_data;
                CFG_SUM_MULT:   keys_reg.sum_mult   <= cfg_data;
                CFG_SUM_ADD:    keys_reg.sum_add    <= cfg_data;
                default:        keys_reg            <= keys_reg;
            endcase
        end
    end

    assign keys = keys_reg;

endmodule

/* rtl/chain_and_sum_modular_mac_core.sv */
// Top level of the chain-and-sum MAC: sequencer, chain and sum state, output register.
// Depends on csmac_pkg, csmac_keys and csmac_mulred.
//
// Computes a two-word MAC modulo 2^31-1 over a stream of 32-bit word pairs. Each input
// transaction carries a pair in s_tdata when s_tuser is high and ends the message when
// s_tlast is high; the MAC then appears as one output transaction and the chain and sum
// state clears. Each pair uses the single multiply-and-reduce unit three times in
// dependent order, plus steps for accepting the transaction, the operand add and the
// state update, before the next transaction is accepted. Closing a message, with or
// without a pair, also loads the MAC output register; an empty transaction that does not
// close leaves the block idle. A finished MAC waits in that register while the next
// message is already accepted, and the next close stalls until it has been taken. Keys
// may be written only while idle.
module chain_and_sum_modular_mac_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] word_first, [63:32] word_second
    input  logic [csmac_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] carries_pair
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [30:0] mac_first, [61:31] mac_second, [63:62] zero
    output logic [csmac_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csmac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csmac_pkg::WORD_W-1:0]    cfg_data
);
    import csmac_pkg::*;

    keys_t              keys;
    mul_op_t            op;
    logic [RES_W-1:0]   res;

    state_t             state_reg;
    state_t             state_next;
    logic [WORD_W-1:0]  w0_reg;
    logic [WORD_W-1:0]  w1f_reg;
    logic               last_reg;
    logic [RES_W-1:0]   t_reg;
    logic [WORD_W-1:0]  u_reg;
    logic [RES_W-1:0]   chain_reg;
    logic [RES_W-1:0]   sum_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [2*RES_W-1:0] m_data_reg;
    logic               accept;
    logic               close_go;

    csmac_keys u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    csmac_mulred u_mulred (
        .aclk (aclk),
        .op   (op),
        .res  (res)
    );

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        state_next = ST_MIX_MUL;
                    end else if (s_tlast) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_MIX_MUL:  state_next = ST_MIX_RED;
            ST_MIX_RED:  state_next = ST_CHN_MUL;
            ST_CHN_MUL:  state_next = ST_CHN_RED;
            ST_CHN_RED:  state_next = ST_SUM_PREP;
            ST_SUM_PREP: state_next = ST_SUM_MUL;
            ST_SUM_MUL:  state_next = ST_SUM_RED;
            ST_SUM_RED:  state_next = ST_UPDATE;
            ST_UPDATE:   state_next = last_reg ? ST_CLOSE : ST_IDLE;
            ST_CLOSE:    state_next = close_go ? ST_IDLE : ST_CLOSE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        close_go = 1'b0;
        op       = '0;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_MIX_MUL: begin
                op.a = w0_reg;
                op.b = MIX_KEY;
                op.d = WORD_W'(chain_reg);
            end
            ST_CHN_MUL: begin
                op.a = WORD_W'(res);
                op.b = keys.chain_mult;
                op.d = keys.chain_add;
            end
            ST_SUM_MUL: begin
                op.a = u_reg;
                op.b = keys.sum_mult;
                op.d = keys.sum_add;
            end
            ST_CLOSE:   close_go = !m_valid_reg || m_tready;
            default:    op = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (close_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            chain_reg   <= '0;
            sum_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_UPDATE) begin
                chain_reg <= res;
                sum_reg   <= fold_add((RES_W+2)'(sum_reg) + (RES_W+2)'(t_reg)
                                      + (RES_W+2)'(res));
            end else if (close_go) begin
                chain_reg <= '0;
                sum_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            w0_reg   <= s_tdata[WORD_W-1:0];
            w1f_reg  <= WORD_W'(s_tdata[2*WORD_W-2:WORD_W]) + WORD_W'(s_tdata[2*WORD_W-1]);
            last_reg <= s_tlast;
        end
        if (state_reg == ST_SUM_PREP) begin
            t_reg <= res;
            u_reg <= w1f_reg + WORD_W'(res);
        end
        if (close_go) begin
            m_data_reg <= {fold_add((RES_W+2)'(sum_reg) + (RES_W+2)'(keys.sum_add)),
                           fold_add((RES_W+2)'(chain_reg) + (RES_W+2)'(keys.chain_add))};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

endmodule

/* rtl/csmac_chk.sv */
// Port-level checker for the chain-and-sum MAC, bound to the top level.
// Depends on csmac_pkg and on the port names of chain_and_sum_modular_mac_core.
module csmac_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csmac_pkg::M_DATA_W-1:0] m_tdata
);
    import csmac_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Both MAC words are fully reduced and the padding is zero.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RES_W-1:0] != MOD_P && m_tdata[2*RES_W-1:RES_W] != MOD_P
                     && m_tdata[M_DATA_W-1:2*RES_W] == '0)
        else $error("MAC word out of range");

    // A pair keeps the block busy in the following cycle.
    a_pair_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready while a pair is absorbed");

    // An empty transaction that does not close the message leaves the input ready in the next cycle.
    a_empty_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !s_tlast |=> s_tready)
        else $error("empty transaction stalled the input");

endmodule

bind chain_and_sum_modular_mac_core csmac_chk u_csmac_chk (.*);

/* test/csmac_checker.sv */
`timescale 1ns / 1ps
// Checker for the chain-and-sum MAC core. It watches the key, input and MAC channels,
// predicts each MAC from its own copy of the keys and state, and counts mismatches.
// Depends on csmac_pkg only.
module csmac_checker
    import csmac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    output int                    mismatches,
    output int                    macs_pending
);

    localparam logic [63:0] PRIME = 64'(MOD_P);

    typedef struct packed {
        logic [RES_W-1:0] mac_first;
        logic [RES_W-1:0] mac_second;
    } mac_t;

    logic [WORD_W-1:0] key_chain_mult;
    logic [WORD_W-1:0] key_chain_add;
    logic [WORD_W-1:0] key_sum_mult;
    logic [WORD_W-1:0] key_sum_add;
    logic [RES_W-1:0]  chain_val;
    logic [RES_W-1:0]  sum_val;
    mac_t              expected_macs[$];

    function automatic logic [63:0] mod_prime(input logic [63:0] x);
        mod_prime = x % PRIME;
    endfunction

    task automatic absorb_item(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                               input logic pair, input logic last);
        logic [63:0] cm, ca, sm, sa, t, c;
        mac_t mac;
        cm = mod_prime(64'(key_chain_mult));
        ca = mod_prime(64'(key_chain_add));
        sm = mod_prime(64'(key_sum_mult));
        sa = mod_prime(64'(key_sum_add));
        if (pair) begin
            t = mod_prime(64'(w0) * 64'(MIX_KEY) + 64'(chain_val));
            t = mod_prime(t * cm + ca);
            c = mod_prime(mod_prime((64'(w1) + t) * sm) + sa);
            chain_val = c[RES_W-1:0];
            sum_val = RES_W'(mod_prime(64'(sum_val) + t + c));
        end
        if (last) begin
            mac.mac_first  = RES_W'(mod_prime(64'(chain_val) + ca));
            mac.mac_second = RES_W'(mod_prime(64'(sum_val) + sa));
            expected_macs.push_back(mac);
            chain_val = '0;
            sum_val = '0;
        end
    endtask

    initial begin
        mismatches = 0;
        macs_pending = 0;
    end

    always @(posedge aclk) begin
        mac_t want;
        if (!aresetn) begin
            key_chain_mult = '0;
            key_chain_add = '0;
            key_sum_mult = '0;
            key_sum_add = '0;
            chain_val = '0;
            sum_val = '0;
            expected_macs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_macs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected MAC transaction, data %h", $realtime, m_tdata);
                    end
                end else begin
                    want = expected_macs.pop_front();
                    if (m_tdata[RES_W-1:0] !== want.mac_first ||
                        m_tdata[2*RES_W-1:RES_W] !== want.mac_second) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: MAC mismatch, expected first %h second %h, got %h %h",
                                     $realtime, want.mac_first, want.mac_second,
                                     m_tdata[RES_W-1:0], m_tdata[2*RES_W-1:RES_W]);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CHAIN_MULT: key_chain_mult = cfg_data;
                    CFG_CHAIN_ADD:  key_chain_add = cfg_data;
                    CFG_SUM_MULT:   key_sum_mult = cfg_data;
                    CFG_SUM_ADD:    key_sum_add = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                absorb_item(s_tdata[WORD_W-1:0], s_tdata[2*WORD_W-1:WORD_W], s_tuser, s_tlast);
            end
        end
        macs_pending = expected_macs.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the chain-and-sum MAC testbench: clock, reset, key writes, message stimulus,
// output back-pressure, watchdog and verdict. Depends on csmac_pkg, the core and csmac_checker.
module testbench;
    import csmac_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 180;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int mismatches;
    int macs_pending;
    int hold_requests;
    int burst_left;
    int items_sent;
    bit no_gaps;

    chain_and_sum_modular_mac_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csmac_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .macs_pending (macs_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       pick_word = '0;
            1:       pick_word = '1;
            2:       pick_word = 32'h7FFF_FFFF;
            3:       pick_word = 32'h8000_0000;
            4:       pick_word = 32'h7FFF_FFFE;
            default: pick_word = $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                             input logic pair, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {w1, w0};
        s_tuser  <= pair;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_message(input int pairs, input bit separate_close);
        for (int i = 0; i < pairs; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item($urandom, $urandom, 1'b0, 1'b0);
            end
            send_item(pick_word(), pick_word(), 1'b1, !separate_close && i == pairs - 1);
            items_sent++;
        end
        if (separate_close || pairs == 0) begin
            send_item($urandom, $urandom, 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    task automatic random_message();
        int pairs;
        bit sep;
        pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        sep = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) begin
            pairs = 0;
        end
        send_message(pairs, sep);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (macs_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key(input cfg_idx_t idx, input logic [WORD_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_keys(input logic [WORD_W-1:0] cm, input logic [WORD_W-1:0] ca,
                             input logic [WORD_W-1:0] sm, input logic [WORD_W-1:0] sa);
        drain();
        write_key(CFG_CHAIN_MULT, cm);
        write_key(CFG_CHAIN_ADD, ca);
        write_key(CFG_SUM_MULT, sm);
        write_key(CFG_SUM_ADD, sa);
        cfg_valid <= 1'b0;
    endtask

    // Output back-pressure: random ready patterns, plus one long hold-off on request.
    initial begin
        int hold_served;
        int rx_mode;
        int rx_left;
        hold_served = 0;
        rx_mode = 0;
        rx_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(20, 120);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL chain_and_sum_modular_mac_core");
        $finish;
    end

    initial begin
        int target;
        logic [WORD_W-1:0] ks [4];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHAIN_MULT;
        cfg_data = '0;
        hold_requests = 0;
        burst_left = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset keys: empty message, idle transaction, word extremes.
        send_item($urandom, $urandom, 1'b0, 1'b1);
        send_item($urandom, $urandom, 1'b0, 1'b0);
        send_item(32'h0, 32'h0, 1'b1, 1'b1);
        send_item('1, '1, 1'b1, 1'b1);

        // Keys at, just below and above the modulus.
        load_keys('1, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000);
        send_item($urandom, $urandom, 1'b0, 1'b1);
        send_item('1, 32'h0, 1'b1, 1'b0);
        send_item(32'h0, '1, 1'b1, 1'b0);
        send_item($urandom, $urandom, 1'b0, 1'b0);
        send_item($urandom, $urandom, 1'b0, 1'b1);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);

        // Key change in the middle of a message.
        load_keys($urandom, $urandom, $urandom, $urandom);
        send_item($urandom, $urandom, 1'b1, 1'b0);
        send_item('1, '1, 1'b1, 1'b0);
        load_keys($urandom, $urandom, $urandom, $urandom);
        send_item($urandom, $urandom, 1'b1, 1'b0);
        send_item($urandom, $urandom, 1'b1, 1'b1);
        send_message(3, 1'b1);
        send_message(2, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            for (int k = 0; k < 4; k++) begin
                case (phase)
                    0:       ks[k] = '1;
                    1:       ks[k] = 32'h7FFF_FFFF;
                    3:       ks[k] = pick_word();
                    4:       ks[k] = '0;
                    default: ks[k] = $urandom;
                endcase
            end
            load_keys(ks[0], ks[1], ks[2], ks[3]);
            if (phase == 2) begin
                hold_requests++;
                no_gaps = 1'b1;
                repeat (16) send_message($urandom_range(1, 2), 1'b0);
                no_gaps = 1'b0;
                drain();
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                random_message();
            end
        end

        drain();
        if (mismatches == 0 && macs_pending == 0) begin
            $display("PASS chain_and_sum_modular_mac_core");
        end else begin
            $display("FAIL chain_and_sum_modular_mac_core");
        end
        $finish;
    end

endmodule
